// File: rtl/binmat_pkg.sv
// Shared constants, codes and types for the binarized matrix product core.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package binmat_pkg;

  // Storage geometry
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int MAX_WORDS = 16;
  localparam int WORD_BITS = 32;

  localparam int LINE_W = $clog2((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS);
  localparam int WIDX_W = $clog2(MAX_WORDS);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int ADDR_W = LINE_W + WIDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // Field and register widths
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 9;
  localparam int ROWS_W  = 7;
  localparam int COLS_W  = 7;
  localparam int WORDS_W = 5;
  localparam int COUNT_W = 10;
  localparam int POP_W   = BIT_W + 1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Register map (word index into paddr)
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORDS = 2'd2;

  localparam logic [ROWS_W-1:0]  ROWS_RESET  = ROWS_W'(64);
  localparam logic [COLS_W-1:0]  COLS_RESET  = COLS_W'(64);
  localparam logic [WORDS_W-1:0] WORDS_RESET = WORDS_W'(16);

  // Sizes after clamping to the storage limits
  typedef struct packed {
    logic [ROWS_W-1:0]  nrows;
    logic [COLS_W-1:0]  ncols;
    logic [WORDS_W-1:0] nwords;
  } size_t;

  // One port set of a sign-word memory
  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

  // Strictly greater than zero: not negative, not +0, not NaN
  function automatic logic is_positive(input logic [31:0] bits);
    logic [7:0]  expo;
    logic [22:0] mant;
    expo = bits[30:23];
    mant = bits[22:0];
    is_positive = !bits[31] && (bits != 32'd0) && !((expo == 8'hFF) && (mant != 23'd0));
  endfunction

endpackage

`default_nettype wire

// File: rtl/binmat_ram.sv
// Sign-word memory: one write port, one registered read port.
// Depends on binmat_pkg.
`default_nettype none

module binmat_ram (
  input  wire logic                          clk,
  input  wire binmat_pkg::mem_req_t          req,
  output logic [binmat_pkg::WORD_BITS-1:0]   rd_data
);

  logic [binmat_pkg::WORD_BITS-1:0] mem [binmat_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/binmat_popcnt.sv
// Shared AND-popcount unit: one word pair per cycle, result registered.
// Depends on binmat_pkg.
`default_nettype none

module binmat_popcnt (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [binmat_pkg::WORD_BITS-1:0]   a_word,
  input  wire logic [binmat_pkg::WORD_BITS-1:0]   b_word,
  output logic                                    valid,
  output logic [binmat_pkg::POP_W-1:0]            count
);

  logic [binmat_pkg::WORD_BITS-1:0] both;
  logic [1:0] s1 [16];
  logic [2:0] s2 [8];
  logic [3:0] s3 [4];
  logic [4:0] s4 [2];
  logic [binmat_pkg::POP_W-1:0] total;

  // adder tree, five levels
  always_comb begin
    both = a_word & b_word;
    for (int i = 0; i < 16; i++) begin
      s1[i] = {1'b0, both[2*i]} + {1'b0, both[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    total = {1'b0, s4[0]} + {1'b0, s4[1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= total;
    end
  end

endmodule

`default_nettype wire

// File: rtl/binmat_ctrl.sv
// Sequencer: bit loads as read-modify-write, queries as a word walk with accumulate.
// Depends on binmat_pkg.
`default_nettype none

module binmat_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire binmat_pkg::size_t                  size,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [binmat_pkg::MODE_W-1:0]      mode,
  input  wire logic [binmat_pkg::IDX_W-1:0]       row_index,
  input  wire logic [binmat_pkg::IDX_W-1:0]       col_index,
  input  wire logic [31:0]                        value_bits,
  output binmat_pkg::mem_req_t                    a_req,
  output binmat_pkg::mem_req_t                    b_req,
  input  wire logic [binmat_pkg::WORD_BITS-1:0]   a_rd_data,
  input  wire logic [binmat_pkg::WORD_BITS-1:0]   b_rd_data,
  output logic                                    pop_start,
  input  wire logic                               pop_valid,
  input  wire logic [binmat_pkg::POP_W-1:0]       pop_count,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [binmat_pkg::COUNT_W-1:0]          product_count,
  output logic                                    index_error
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LD_RD = 3'd1;
  localparam logic [2:0] S_LD_WR = 3'd2;
  localparam logic [2:0] S_Q_RUN = 3'd3;
  localparam logic [2:0] S_Q_END = 3'd4;

  localparam int LIM_PAD = binmat_pkg::IDX_W - binmat_pkg::ROWS_W;

  logic [2:0] state;
  logic       rd_pend;

  logic                                 ld_sel_b;
  logic [binmat_pkg::ADDR_W-1:0]        ld_addr;
  logic [binmat_pkg::BIT_W-1:0]         ld_bit;
  logic                                 ld_val;
  logic [binmat_pkg::LINE_W-1:0]        q_row;
  logic [binmat_pkg::LINE_W-1:0]        q_col;
  logic                                 q_err;
  logic [binmat_pkg::WORDS_W-1:0]       word_cnt;
  logic [binmat_pkg::COUNT_W-1:0]       acc;

  logic                                 accept;
  logic [binmat_pkg::IDX_W-1:0]         line;
  logic [binmat_pkg::IDX_W-1:0]         inner;
  logic [binmat_pkg::IDX_W-1:0]         line_lim;
  logic [binmat_pkg::WIDX_W-1:0]        inner_word;
  logic                                 ld_ok;
  logic                                 q_ok;
  logic                                 q_last;
  logic                                 q_finish;
  logic [binmat_pkg::WORD_BITS-1:0]     merged;
  logic [binmat_pkg::ADDR_W-1:0]        a_walk;
  logic [binmat_pkg::ADDR_W-1:0]        b_walk;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // load geometry: A is stored by row, B by column
  always_comb begin
    if (mode == binmat_pkg::MODE_LOAD_A) begin
      line     = row_index;
      inner    = col_index;
      line_lim = {{LIM_PAD{1'b0}}, size.nrows};
    end else begin
      line     = col_index;
      inner    = row_index;
      line_lim = {{LIM_PAD{1'b0}}, size.ncols};
    end
    inner_word = inner[binmat_pkg::IDX_W-1:binmat_pkg::BIT_W];
    ld_ok = (line < line_lim) && ({1'b0, inner_word} < size.nwords);
    q_ok  = (row_index < {{LIM_PAD{1'b0}}, size.nrows}) &&
            (col_index < {{LIM_PAD{1'b0}}, size.ncols});
  end

  assign q_last   = (binmat_pkg::WORDS_W'(word_cnt + 1'b1) == size.nwords);
  assign q_finish = (state == S_Q_END) && !rd_pend && !pop_valid &&
                    (!out_valid || out_ready);

  always_comb begin
    merged = ld_sel_b ? b_rd_data : a_rd_data;
    merged[ld_bit] = ld_val;
  end

  assign a_walk = {q_row, word_cnt[binmat_pkg::WIDX_W-1:0]};
  assign b_walk = {q_col, word_cnt[binmat_pkg::WIDX_W-1:0]};

  always_comb begin
    a_req.rd_en   = (state == S_Q_RUN) || ((state == S_LD_RD) && !ld_sel_b);
    a_req.rd_addr = (state == S_Q_RUN) ? a_walk : ld_addr;
    a_req.wr_en   = (state == S_LD_WR) && !ld_sel_b;
    a_req.wr_addr = ld_addr;
    a_req.wr_data = merged;
    b_req.rd_en   = (state == S_Q_RUN) || ((state == S_LD_RD) && ld_sel_b);
    b_req.rd_addr = (state == S_Q_RUN) ? b_walk : ld_addr;
    b_req.wr_en   = (state == S_LD_WR) && ld_sel_b;
    b_req.wr_addr = ld_addr;
    b_req.wr_data = merged;
  end

  // read data lands in the cycle after the walk issues it
  assign pop_start = rd_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == S_Q_RUN);
      if (q_finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (mode) inside
              binmat_pkg::MODE_LOAD_A, binmat_pkg::MODE_LOAD_B: begin
                if (ld_ok) begin
                  state <= S_LD_RD;
                end
              end
              binmat_pkg::MODE_QUERY: begin
                if (q_ok && (size.nwords != '0)) begin
                  state <= S_Q_RUN;
                end else begin
                  state <= S_Q_END;
                end
              end
              default: ;
            endcase
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: state <= S_IDLE;
        S_Q_RUN: begin
          if (q_last) begin
            state <= S_Q_END;
          end
        end
        S_Q_END: begin
          if (q_finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_sel_b <= (mode == binmat_pkg::MODE_LOAD_B);
      ld_addr  <= {line[binmat_pkg::LINE_W-1:0], inner_word};
      ld_bit   <= inner[binmat_pkg::BIT_W-1:0];
      ld_val   <= binmat_pkg::is_positive(value_bits);
      q_row    <= row_index[binmat_pkg::LINE_W-1:0];
      q_col    <= col_index[binmat_pkg::LINE_W-1:0];
      q_err    <= !q_ok;
      word_cnt <= '0;
      acc      <= '0;
    end else begin
      if (state == S_Q_RUN) begin
        word_cnt <= word_cnt + 1'b1;
      end
      if (pop_valid) begin
        acc <= acc + binmat_pkg::COUNT_W'(pop_count);
      end
    end
    if (q_finish) begin
      product_count <= acc;
      index_error   <= q_err;
    end
  end

endmodule

`default_nettype wire

// File: rtl/binary_matrix_product_core.sv
// Top level of the binarized matrix product core: register port, memories, datapath.
// Depends on binmat_pkg, binmat_ram, binmat_popcnt, binmat_ctrl.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | in_valid / in_ready        | mode, row_index, col_index, value_bits
//  output   | out_valid / out_ready      | product_count, index_error
//  config   | psel, penable, pwrite, ... | paddr, pwdata, prdata (APB-style)
//
// A load steps through accept, memory read and write back of the modified word.
// An in-range query walks min(inner_words, 16) word pairs, one word pair per cycle
// through the shared AND-popcount unit.
// Synchronous rst sets the size registers; memories are not cleared (undefined until loaded).
// A finished query waits in the output register while out_ready is low, and the next
// query holds at its end until it frees; loads still proceed meanwhile.
`default_nettype none

module binary_matrix_product_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [binmat_pkg::MODE_W-1:0]       mode,
  input  wire logic [binmat_pkg::IDX_W-1:0]        row_index,
  input  wire logic [binmat_pkg::IDX_W-1:0]        col_index,
  input  wire logic [31:0]                         value_bits,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [binmat_pkg::COUNT_W-1:0]           product_count,
  output logic                                     index_error,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [binmat_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  logic [binmat_pkg::ROWS_W-1:0]  rows_in_use;
  logic [binmat_pkg::COLS_W-1:0]  cols_in_use;
  logic [binmat_pkg::WORDS_W-1:0] inner_words;

  logic [binmat_pkg::REG_IDX_W-1:0] reg_idx;
  logic                             reg_wr;

  binmat_pkg::size_t    size;
  binmat_pkg::mem_req_t a_req;
  binmat_pkg::mem_req_t b_req;

  logic [binmat_pkg::WORD_BITS-1:0] a_rd_data;
  logic [binmat_pkg::WORD_BITS-1:0] b_rd_data;
  logic                             pop_start;
  logic                             pop_valid;
  logic [binmat_pkg::POP_W-1:0]     pop_count;

  // register port: zero wait states, word-aligned map
  assign pready  = 1'b1;
  assign reg_idx = paddr[binmat_pkg::PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= binmat_pkg::ROWS_RESET;
      cols_in_use <= binmat_pkg::COLS_RESET;
      inner_words <= binmat_pkg::WORDS_RESET;
    end else if (reg_wr) begin
      unique case (reg_idx)
        binmat_pkg::REG_ROWS:  rows_in_use <= pwdata[binmat_pkg::ROWS_W-1:0];
        binmat_pkg::REG_COLS:  cols_in_use <= pwdata[binmat_pkg::COLS_W-1:0];
        binmat_pkg::REG_WORDS: inner_words <= pwdata[binmat_pkg::WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      binmat_pkg::REG_ROWS:  prdata = 32'(rows_in_use);
      binmat_pkg::REG_COLS:  prdata = 32'(cols_in_use);
      binmat_pkg::REG_WORDS: prdata = 32'(inner_words);
      default:               prdata = 32'd0;
    endcase
  end

  // sizes above the storage limits act as the limits
  always_comb begin
    size.nrows  = (rows_in_use > binmat_pkg::ROWS_W'(binmat_pkg::MAX_ROWS)) ?
                  binmat_pkg::ROWS_W'(binmat_pkg::MAX_ROWS) : rows_in_use;
    size.ncols  = (cols_in_use > binmat_pkg::COLS_W'(binmat_pkg::MAX_COLS)) ?
                  binmat_pkg::COLS_W'(binmat_pkg::MAX_COLS) : cols_in_use;
    size.nwords = (inner_words > binmat_pkg::WORDS_W'(binmat_pkg::MAX_WORDS)) ?
                  binmat_pkg::WORDS_W'(binmat_pkg::MAX_WORDS) : inner_words;
  end

  // A sign words, row-major by inner word
  binmat_ram u_a_ram (
    .clk     (clk),
    .req     (a_req),
    .rd_data (a_rd_data)
  );

  // B sign words, column-major by inner word
  binmat_ram u_b_ram (
    .clk     (clk),
    .req     (b_req),
    .rd_data (b_rd_data)
  );

  binmat_popcnt u_popcnt (
    .clk    (clk),
    .rst    (rst),
    .start  (pop_start),
    .a_word (a_rd_data),
    .b_word (b_rd_data),
    .valid  (pop_valid),
    .count  (pop_count)
  );

  binmat_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .size          (size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .row_index     (row_index),
    .col_index     (col_index),
    .value_bits    (value_bits),
    .a_req         (a_req),
    .b_req         (b_req),
    .a_rd_data     (a_rd_data),
    .b_rd_data     (b_rd_data),
    .pop_start     (pop_start),
    .pop_valid     (pop_valid),
    .pop_count     (pop_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_count (product_count),
    .index_error   (index_error)
  );

endmodule

`default_nettype wire

// File: verif/binary_matrix_product_core_tb.sv
// Self-checking testbench for binary_matrix_product_core: sign-bit loads, popcount queries,
// size registers over the APB-style port. Depends on rtl/binmat_pkg.sv and the core RTL.
// Results are checked in order against a built-in model of the sign memories and sizes.
`default_nettype none

module binary_matrix_product_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import binmat_pkg::*;

  // Mode 3 has no name in the package; the core drops it on accept.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Loads give no result, so wait a bit past the last result
  // before touching the size registers.
  localparam int DRAIN_CYCLES = 8;
  // Run limit, far above the slowest correct run.
  localparam int RUN_LIMIT_NS = 10_000_000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [31:0]       value;
  } request_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               err;
  } product_t;

  // One line of the directed script: either a register write or a request,
  // optionally with its result spelled out.
  typedef struct packed {
    bit                   is_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_size;
    request_t             req;
    bit                   typed;
    product_t             typed_result;
  } script_line_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode       = '0;
  logic [IDX_W-1:0]   row_index  = '0;
  logic [IDX_W-1:0]   col_index  = '0;
  logic [31:0]        value_bits = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [COUNT_W-1:0] product_count;
  logic               index_error;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [31:0]        pwdata     = '0;
  logic [31:0]        prdata;
  logic               pready;

  binary_matrix_product_core u_top (
    .clk, .rst,
    .in_valid, .in_ready, .mode, .row_index, .col_index, .value_bits,
    .out_valid, .out_ready, .product_count, .index_error,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model state: our own copy of the size registers and of both sign memories.
  // The *_known arrays track which bits were ever loaded; the RTL memories are
  // undefined until written, so a query may only touch fully loaded words.
  // ---------------------------------------------------------------------------
  logic [ROWS_W-1:0]    rows_cfg;
  logic [COLS_W-1:0]    cols_cfg;
  logic [WORDS_W-1:0]   words_cfg;
  logic [WORD_BITS-1:0] a_signs [MAX_ROWS][MAX_WORDS];
  logic [WORD_BITS-1:0] b_signs [MAX_COLS][MAX_WORDS];
  logic [WORD_BITS-1:0] a_known [MAX_ROWS][MAX_WORDS];
  logic [WORD_BITS-1:0] b_known [MAX_COLS][MAX_WORDS];

  product_t     expected_products [$];
  script_line_t directed_script [$];
  int           a_lines [$];   // A rows kept fully loaded in this phase
  int           b_lines [$];   // B columns kept fully loaded in this phase
  int           failures     = 0;
  int           send_gap_pct = 0;
  int           stall_pct    = 0;

  function automatic int clamp_to(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic int rows_now();
    return clamp_to(rows_cfg, MAX_ROWS);
  endfunction

  function automatic int cols_now();
    return clamp_to(cols_cfg, MAX_COLS);
  endfunction

  function automatic int words_now();
    return clamp_to(words_cfg, MAX_WORDS);
  endfunction

  // Sign clear and magnitude in (0, +inf]: positive normals, subnormals, +inf.
  // Zero magnitude and anything above the +inf pattern (NaN) fall out.
  function automatic bit above_zero(logic [31:0] v);
    return !v[31] && (v[30:0] != 31'd0) && (v[30:0] <= 31'h7F80_0000);
  endfunction

  // True when every inner word in use is loaded for both A row r and B column c.
  function automatic bit line_ready(int r, int c);
    for (int w = 0; w < words_now(); w++)
      if (~a_known[r][w] != '0 || ~b_known[c][w] != '0) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one accepted request to the model; returns the product it yields, if any.
  task automatic predict_product(input request_t q, output bit has_result,
                                 output product_t result);
    int nr, nc, nw, r, c, total;
    nr = rows_now();
    nc = cols_now();
    nw = words_now();
    r  = q.row;
    c  = q.col;
    has_result = 1'b0;
    result     = '0;
    case (q.mode)
      MODE_LOAD_A: begin
        if (r < nr && c < nw * WORD_BITS) begin
          a_signs[r][c / WORD_BITS][c % WORD_BITS] = above_zero(q.value);
          a_known[r][c / WORD_BITS][c % WORD_BITS] = 1'b1;
        end
      end
      MODE_LOAD_B: begin
        // B is stored by column: row_index is the inner position here
        if (r < nw * WORD_BITS && c < nc) begin
          b_signs[c][r / WORD_BITS][r % WORD_BITS] = above_zero(q.value);
          b_known[c][r / WORD_BITS][r % WORD_BITS] = 1'b1;
        end
      end
      MODE_QUERY: begin
        has_result = 1'b1;
        if (r >= nr || c >= nc) begin
          result.err = 1'b1;
        end else begin
          total = 0;
          for (int w = 0; w < nw; w++)
            total += $countones(a_signs[r][w] & b_signs[c][w]);
          result.count = total[COUNT_W-1:0];
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Payload changes at the falling edge; acceptance is seen at
  // the rising edge. Valid stays high between back-to-back requests.
  // ---------------------------------------------------------------------------
  task automatic issue(input request_t q, input bit typed, input product_t typed_result);
    bit       has_result;
    product_t result;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    mode       = q.mode;
    row_index  = q.row;
    col_index  = q.col;
    value_bits = q.value;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_product(q, has_result, result);
    if (has_result) expected_products.push_back(typed ? typed_result : result);
  endtask

  task automatic send(input logic [MODE_W-1:0] m, input int r, input int c,
                      input logic [31:0] v);
    issue('{mode: m, row: IDX_W'(r), col: IDX_W'(c), value: v}, 1'b0, '0);
  endtask

  // Drop valid, let every expected result come back, then let loads finish.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle. Bits above the register
  // width carry random junk; the core keeps only the low bits.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int size);
    logic [31:0] data;
    data = $urandom();
    case (idx)
      REG_ROWS:  data[ROWS_W-1:0]  = ROWS_W'(size);
      REG_COLS:  data[COLS_W-1:0]  = COLS_W'(size);
      REG_WORDS: data[WORDS_W-1:0] = WORDS_W'(size);
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_ROWS:  rows_cfg  = data[ROWS_W-1:0];
      REG_COLS:  cols_cfg  = data[COLS_W-1:0];
      REG_WORDS: words_cfg = data[WORDS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Element values spread over the float classes that matter for the sign test.
  function automatic logic [31:0] pick_value(bit positive_only);
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(positive_only ? 3 : 9))
      0: v = {1'b0, 8'($urandom_range(1, 254)), v[22:0]};  // positive normal
      1: v = {9'd0, v[22:1], 1'b1};                        // positive subnormal
      2: v = 32'h7F80_0000;                                // +inf
      3: v = 32'h7F7F_FFFF;                                // largest finite
      4: v = 32'h0000_0000;                                // +0
      5: v = 32'h8000_0000;                                // -0
      6: v[31] = 1'b1;                                     // any negative, -NaN too
      7: v = {1'b0, 8'hFF, v[22:1], 1'b1};                 // positive NaN
      default: ;                                           // raw random pattern
    endcase
    return v;
  endfunction

  // Load every inner bit in use of the phase's lines (all of them, or only the
  // bits never loaded), then query each A row against each B column.
  task automatic fill_lines(input bit overwrite, input bit a_positive, input bit b_positive);
    int ninner;
    ninner = words_now() * WORD_BITS;
    foreach (a_lines[i])
      for (int k = 0; k < ninner; k++)
        if (overwrite || !a_known[a_lines[i]][k / WORD_BITS][k % WORD_BITS])
          send(MODE_LOAD_A, a_lines[i], k, pick_value(a_positive));
    foreach (b_lines[i])
      for (int k = 0; k < ninner; k++)
        if (overwrite || !b_known[b_lines[i]][k / WORD_BITS][k % WORD_BITS])
          send(MODE_LOAD_B, k, b_lines[i], pick_value(b_positive));
    foreach (a_lines[i])
      foreach (b_lines[j])
        send(MODE_QUERY, a_lines[i], b_lines[j], $urandom());
  endtask

  // Random traffic: mostly bit flips inside loaded lines and queries on them,
  // plus in-range loads elsewhere, loads and queries anywhere, and mode 3.
  task automatic random_requests(input int count);
    int pick, r, c, ninner;
    for (int n = 0; n < count; n++) begin
      ninner = words_now() * WORD_BITS;
      pick   = $urandom_range(99);
      if (pick < 35) begin
        if ($urandom_range(1))
          send(MODE_LOAD_A, a_lines[$urandom_range(a_lines.size() - 1)],
               $urandom_range(ninner - 1), pick_value(1'b0));
        else
          send(MODE_LOAD_B, $urandom_range(ninner - 1),
               b_lines[$urandom_range(b_lines.size() - 1)], pick_value(1'b0));
      end else if (pick < 45) begin
        if ($urandom_range(1))
          send(MODE_LOAD_A, $urandom_range(rows_now() - 1), $urandom_range(ninner - 1),
               pick_value(1'b0));
        else
          send(MODE_LOAD_B, $urandom_range(ninner - 1), $urandom_range(cols_now() - 1),
               pick_value(1'b0));
      end else if (pick < 55) begin
        send($urandom_range(1) ? MODE_LOAD_A : MODE_LOAD_B, $urandom_range(511),
             $urandom_range(511), pick_value(1'b0));
      end else if (pick < 85) begin
        send(MODE_QUERY, a_lines[$urandom_range(a_lines.size() - 1)],
             b_lines[$urandom_range(b_lines.size() - 1)], $urandom());
      end else if (pick < 95) begin
        // anywhere; an in-range pair that is not fully loaded is pushed out of range
        r = $urandom_range(511);
        c = $urandom_range(511);
        if (r < rows_now() && c < cols_now() && !line_ready(r, c)) r = r | 256;
        send(MODE_QUERY, r, c, $urandom());
      end else begin
        send(MODE_UNUSED, $urandom_range(511), $urandom_range(511), $urandom());
      end
    end
  endtask

  task automatic run_phase(input int rows, input int cols, input int words,
                           input int gap_pct, input int stall, input int count,
                           input bit overwrite, input bit a_positive, input bit b_positive);
    settle();
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_WORDS, words);
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    fill_lines(overwrite, a_positive, b_positive);
    random_requests(count);
  endtask

  // Directed script builders
  function automatic void script_reg(input logic [REG_IDX_W-1:0] idx, input int size);
    directed_script.push_back('{is_reg: 1'b1, reg_idx: idx, reg_size: size, default: '0});
  endfunction

  function automatic void script_req(input logic [MODE_W-1:0] m, input int r, input int c,
                                     input logic [31:0] v);
    directed_script.push_back('{is_reg: 1'b0, reg_idx: '0, reg_size: '0,
                                req: '{m, IDX_W'(r), IDX_W'(c), v},
                                typed: 1'b0, typed_result: '0});
  endfunction

  // A query whose result is written out by hand
  function automatic void script_query(input int r, input int c, input int cnt,
                                       input logic err);
    directed_script.push_back('{is_reg: 1'b0, reg_idx: '0, reg_size: '0,
                                req: '{MODE_QUERY, IDX_W'(r), IDX_W'(c), 32'h0},
                                typed: 1'b1, typed_result: '{COUNT_W'(cnt), err}});
  endfunction

  // Receiver stalls are drawn fresh every cycle.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checker: in-order compare against the oldest expectation.
  always @(posedge clk) begin : check_results
    product_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_products.size() == 0) begin
        $error("result with nothing expected: product_count %0d index_error %0b",
               product_count, index_error);
        failures++;
      end else begin
        want = expected_products.pop_front();
        if (product_count !== want.count) begin
          $error("product_count: expected %0d, got %0d", want.count, product_count);
          failures++;
        end
        if (index_error !== want.err) begin
          $error("index_error: expected %0b, got %0b", want.err, index_error);
          failures++;
        end
      end
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("binary_matrix_product_core test failed");
    $finish;
  end

  initial begin
    rows_cfg  = ROWS_RESET;
    cols_cfg  = COLS_RESET;
    words_cfg = WORDS_RESET;
    foreach (a_known[i, j]) begin
      a_known[i][j] = '0;
      a_signs[i][j] = '0;
    end
    foreach (b_known[i, j]) begin
      b_known[i][j] = '0;
      b_signs[i][j] = '0;
    end

    // Directed part, starting from the reset sizes 64 x 64 x 16 words.
    script_query(64, 0, 0, 1'b1);                       // row just past the end
    script_query(0, 64, 0, 1'b1);                       // column just past the end
    script_query(511, 511, 0, 1'b1);                    // both indices at field max
    script_req(MODE_LOAD_A, 64, 0, 32'h3F80_0000);      // out-of-range load, dropped
    script_req(MODE_LOAD_B, 511, 63, 32'hFFFF_FFFF);    // last inner bit, -NaN
    script_req(MODE_LOAD_A, 63, 511, 32'h7F80_0000);    // last inner bit, +inf
    script_req(MODE_UNUSED, 511, 511, 32'hFFFF_FFFF);   // dropped on accept
    // zero inner words: in-range query counts nothing
    script_reg(REG_ROWS, 1);
    script_reg(REG_COLS, 1);
    script_reg(REG_WORDS, 0);
    script_query(0, 0, 0, 1'b0);
    script_query(0, 1, 0, 1'b1);
    script_req(MODE_LOAD_A, 0, 0, 32'h3F80_0000);       // no inner space: ignored
    // zero rows, then zero columns: every query is out of range
    script_reg(REG_ROWS, 0);
    script_query(0, 0, 0, 1'b1);
    script_reg(REG_ROWS, 1);
    script_reg(REG_COLS, 0);
    script_query(0, 0, 0, 1'b1);
    // Float classes into A row 0; B column 0 is loaded all-positive later, so
    // the first query of phase one exposes these sign bits with the rest of the row.
    script_reg(REG_ROWS, 2);
    script_reg(REG_COLS, 2);
    script_reg(REG_WORDS, 1);
    script_req(MODE_LOAD_A, 0, 0, 32'h3F80_0000);       // +1.0
    script_req(MODE_LOAD_A, 0, 1, 32'h0000_0001);       // smallest subnormal
    script_req(MODE_LOAD_A, 0, 2, 32'h7F80_0000);       // +inf
    script_req(MODE_LOAD_A, 0, 3, 32'h7F7F_FFFF);       // largest finite
    script_req(MODE_LOAD_A, 0, 4, 32'h0000_0000);       // +0
    script_req(MODE_LOAD_A, 0, 5, 32'h8000_0000);       // -0
    script_req(MODE_LOAD_A, 0, 6, 32'hBF80_0000);       // -1.0
    script_req(MODE_LOAD_A, 0, 7, 32'h7FC0_0000);       // quiet NaN
    script_req(MODE_LOAD_A, 0, 8, 32'h7F80_0001);       // signaling NaN

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Sender idles 10 %, receiver stalls 50 % through the directed part and phase one.
    send_gap_pct = 10;
    stall_pct    = 50;
    foreach (directed_script[i]) begin
      if (directed_script[i].is_reg) begin
        settle();
        write_reg(directed_script[i].reg_idx, directed_script[i].reg_size);
      end else begin
        issue(directed_script[i].req, directed_script[i].typed,
              directed_script[i].typed_result);
      end
    end

    // Phase one: 4 x 4, one inner word. Finish A row 0, B column 0 all positive.
    a_lines = '{0, $urandom_range(1, 3)};
    b_lines = '{0, $urandom_range(1, 3)};
    run_phase(4, 4, 1, 10, 50, 40, 1'b0, 1'b0, 1'b1);

    // Phase two: rows above the limit act as 64, last column in use, two words.
    a_lines = '{0, $urandom_range(1, 63)};
    b_lines = '{0, 63};
    run_phase(127, 64, 2, 50, 10, 40, 1'b0, 1'b0, 1'b0);

    // Phase three: one row, columns and words above their limits. Every bit of
    // the chosen lines rewritten positive, so the first query hits the full 512.
    a_lines = '{0};
    b_lines = '{$urandom_range(0, 63)};
    run_phase(1, 127, 31, 0, 0, 20, 1'b1, 1'b1, 1'b1);

    settle();
    if (failures == 0)
      $display("binary_matrix_product_core test passed");
    else
      $display("binary_matrix_product_core test failed");
    $finish;
  end

endmodule

`default_nettype wire
